@@ hw/rtl/dtiv_pkg.sv @@
`timescale 1ns / 1ps

package dtiv_pkg;

    // Field types of one input word and of the result.
    typedef logic [4:0]  day_t;
    typedef logic [3:0]  month_t;
    typedef logic [11:0] year_t;
    typedef logic [20:0] daynum_t;

    // Index into the month table; entry 12 is a whole year.
    typedef logic [3:0]  month_idx_t;
    localparam month_idx_t LAST_MONTH_IDX = 4'd12;

    // Days before the start of each month in a common year.
    localparam logic [8:0] DAYS_BEFORE [13] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Division by 25 as a multiply by 1311 and a shift by 15.
    // It is exact for every dividend up to 1123, which covers all uses here.
    localparam logic [10:0] RECIP_25   = 11'd1311;
    localparam int          RECIP_SHIFT = 15;
    localparam logic [4:0]  DIV_25      = 5'd25;
    localparam logic [8:0]  DAYS_YEAR   = 9'd365;

endpackage

@@ hw/rtl/dtiv_day_number.sv @@
`timescale 1ns / 1ps

module dtiv_day_number #(
    parameter int unsigned MAX_YEAR = 4095
) (
    input  logic              clk,
    input  logic              en,
    input  dtiv_pkg::day_t    day,
    input  dtiv_pkg::month_t  month,
    input  dtiv_pkg::year_t   year,
    output dtiv_pkg::daynum_t daynum
);
    import dtiv_pkg::*;

    // Saturation limit, never above what the year field can carry.
    localparam int unsigned SAT_INT  = (MAX_YEAR < 4095) ? MAX_YEAR : 4095;
    localparam year_t       SAT_YEAR = year_t'(SAT_INT);

    // Stage 1 registers.
    year_t       y1_reg;
    logic [21:0] p100_reg;
    logic [21:0] p400_reg;
    logic [21:0] pyr_reg;
    logic [8:0]  md1_reg;
    logic        late1_reg;

    // Stage 2 registers.
    logic [20:0] yd2_reg;
    logic [10:0] corr2_reg;
    logic [8:0]  md2_reg;
    logic        leap2_reg;

    // Stage 3 register.
    daynum_t     num3_reg;

    // Stage 1: saturate the year, start the divisions, read the month table.
    year_t       y_sat;
    logic [12:0] y_plus99;
    logic [12:0] y_plus399;
    month_idx_t  idx;
    logic [8:0]  md_next;

    always_comb
    begin
        y_sat     = (year > SAT_YEAR) ? SAT_YEAR : year;
        y_plus99  = {1'b0, y_sat} + 13'd99;
        y_plus399 = {1'b0, y_sat} + 13'd399;
        if (month == '0)
        begin
            idx = '0;
        end
        else if (month > 4'd13)
        begin
            idx = LAST_MONTH_IDX;
        end
        else
        begin
            idx = month_idx_t'(month - 4'd1);
        end
        md_next = DAYS_BEFORE[idx] + {4'd0, day};
    end

    function automatic logic [9:0] y1_dummy_free(input year_t y);
        return y[11:2];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y1_reg    <= y_sat;
            p100_reg  <= {11'd0, y_plus99[12:2]} * {11'd0, RECIP_25};
            p400_reg  <= {13'd0, y_plus399[12:4]} * {11'd0, RECIP_25};
            pyr_reg   <= {12'd0, y1_dummy_free(y_sat)} * {11'd0, RECIP_25};
            md1_reg   <= md_next;
            late1_reg <= (idx >= month_idx_t'(2));
        end
    end

    // Stage 2: finish the divisions, find the leap year, scale whole years.
    logic [6:0]  q100;
    logic [6:0]  q400;
    logic [6:0]  qyr;
    logic [9:0]  r25;
    logic        is_leap;
    logic [10:0] corr_next;

    always_comb
    begin
        q100      = p100_reg[RECIP_SHIFT +: 7];
        q400      = p400_reg[RECIP_SHIFT +: 7];
        qyr       = pyr_reg[RECIP_SHIFT +: 7];
        r25       = y1_reg[11:2] - ({3'd0, qyr} * {5'd0, DIV_25});
        is_leap   = (y1_reg[1:0] == 2'd0) && ((r25 != '0) || (qyr[1:0] == 2'd0));
        corr_next = 11'(({1'b0, y1_reg} + 13'd3) >> 2) - {4'd0, q100} + {4'd0, q400};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yd2_reg   <= {9'd0, y1_reg} * {12'd0, DAYS_YEAR};
            corr2_reg <= corr_next;
            md2_reg   <= md1_reg;
            leap2_reg <= is_leap && late1_reg;
        end
    end

    // Stage 3: add up the day number.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num3_reg <= yd2_reg + {10'd0, corr2_reg} + {12'd0, md2_reg}
                        + {20'd0, leap2_reg};
        end
    end

    assign daynum = num3_reg;

endmodule

@@ hw/rtl/date_interval_days.sv @@
`timescale 1ns / 1ps

// Distance in days between two proleptic Gregorian dates. Each input word holds
// two dates; one result word gives the absolute difference of their day numbers.
// The block takes one word in every cycle while no finished result waits on
// out_ready. Three stages form each day number (divisions by 100 and 400 done as
// reciprocal multiplies, then the leap test and year scaling, then the final
// sum) and a fourth takes the difference. The whole pipeline holds while a
// finished result waits on out_ready. Days are not checked against month length,
// and years above MAX_YEAR count as MAX_YEAR.
module date_interval_days #(
    parameter int unsigned MAX_YEAR = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dtiv_pkg::day_t    first_day,
    input  dtiv_pkg::month_t  first_month,
    input  dtiv_pkg::year_t   first_year,
    input  dtiv_pkg::day_t    second_day,
    input  dtiv_pkg::month_t  second_month,
    input  dtiv_pkg::year_t   second_year,
    output logic              out_valid,
    input  logic              out_ready,
    output dtiv_pkg::daynum_t interval_days
);
    import dtiv_pkg::*;

    // Pipeline advances whenever the output stage is empty or being taken.
    logic       adv;
    logic [3:0] vld_reg;
    logic [3:0] vld_next;

    assign adv      = !vld_reg[3] || out_ready;
    assign in_ready = adv;
    assign vld_next = adv ? {vld_reg[2:0], in_valid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Day numbers of both dates.
    daynum_t num_a;
    daynum_t num_b;

    dtiv_day_number #(
        .MAX_YEAR (MAX_YEAR)
    ) u_first (
        .clk    (clk),
        .en     (adv),
        .day    (first_day),
        .month  (first_month),
        .year   (first_year),
        .daynum (num_a)
    );

    dtiv_day_number #(
        .MAX_YEAR (MAX_YEAR)
    ) u_second (
        .clk    (clk),
        .en     (adv),
        .day    (second_day),
        .month  (second_month),
        .year   (second_year),
        .daynum (num_b)
    );

    // Output stage: absolute difference of the two day numbers.
    daynum_t diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
        end
    end

    assign out_valid     = vld_reg[3];
    assign interval_days = diff_reg;

    // A stalled input means a result word is waiting at the output.
    a_stall_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> vld_reg[3])
        else $error("input stalled with no result word waiting");

    // An accepted word enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted word did not enter the pipeline");

    // A stall keeps every word in flight where it is.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !out_ready) |=> (vld_reg == $past(vld_reg)))
        else $error("word moved or lost during a stall");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import dtiv_pkg::*;

    // Stop if this many cycles pass with no word moving on either side.
    localparam int STALL_LIMIT = 2000;
    // Largest year the block is built for; higher years count as this one.
    localparam int unsigned YEAR_CEILING = 4095;
    // Cycles to wait once nothing is outstanding (four stages plus margin).
    localparam int SETTLE_CYCLES = 8;

    // Days before the start of each month in a common year; entry 12 is a full year.
    localparam int unsigned MONTH_START [13] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    day_t    first_day = '0;
    month_t  first_month = '0;
    year_t   first_year = '0;
    day_t    second_day = '0;
    month_t  second_month = '0;
    year_t   second_year = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    daynum_t interval_days;

    // Expected intervals, oldest first.
    daynum_t interval_q[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      idle_on = 1'b1;

    date_interval_days uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .interval_days(interval_days)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_leap_year(int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Day number counted from year 0, which is itself a leap year.
    function automatic int unsigned day_count(day_t d, month_t m, year_t y);
        int unsigned yr;
        int unsigned idx;
        int unsigned n;
        yr = y;
        if (yr > YEAR_CEILING)
            yr = YEAR_CEILING;
        n = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400;
        // Month zero adds nothing; months past twelve add the whole year.
        idx = (m == 0) ? 0 : m - 1;
        if (idx > 12)
            idx = 12;
        n += MONTH_START[idx];
        if (idx >= 2 && is_leap_year(yr))
            n += 1;
        return n + d;
    endfunction

    function automatic daynum_t days_apart(day_t d1, month_t m1, year_t y1,
                                           day_t d2, month_t m2, year_t y2);
        int unsigned a;
        int unsigned b;
        a = day_count(d1, m1, y1);
        b = day_count(d2, m2, y2);
        return (a > b) ? daynum_t'(a - b) : daynum_t'(b - a);
    endfunction

    // Record each accepted word and check each delivered result.
    always @(posedge clk)
    begin
        daynum_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                interval_q.push_back(days_apart(first_day, first_month, first_year,
                                                second_day, second_month, second_year));
            if (out_valid && out_ready)
            begin
                if (interval_q.size() == 0)
                begin
                    $error("interval_days: no result expected, got %0d", interval_days);
                    mismatches++;
                end
                else
                begin
                    want = interval_q.pop_front();
                    if (interval_days !== want)
                    begin
                        $error("interval_days: expected %0d, got %0d", want, interval_days);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no word moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    // Result side: random stalls between ready stretches while idle_on is set.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // Send one word; valid stays high on return so the next word can follow at once.
    task automatic send_dates(day_t d1, month_t m1, year_t y1,
                              day_t d2, month_t m2, year_t y2);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        first_day    <= d1;
        first_month  <= m1;
        first_year   <= y1;
        second_day   <= d2;
        second_month <= m2;
        second_year  <= y2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (interval_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A calendar-valid date; a year below zero means pick one at random.
    task automatic pick_date(input int fixed_year, output day_t d, output month_t m,
                             output year_t y);
        int unsigned len;
        y = (fixed_year < 0) ? year_t'($urandom_range(0, 4095)) : year_t'(fixed_year);
        m = month_t'($urandom_range(1, 12));
        case (m)
            4'd2: len = is_leap_year(y) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 30;
            default: len = 31;
        endcase
        d = day_t'($urandom_range(1, len));
    endtask

    // Field extremes, leap rules and the unchecked day and month cases.
    task automatic run_directed;
        send_dates(5'd1, 4'd1, 12'd0, 5'd1, 4'd1, 12'd0);
        send_dates(5'd1, 4'd1, 12'd0, 5'd31, 4'd12, 12'd4095);
        send_dates(5'd31, 4'd12, 12'd4095, 5'd1, 4'd1, 12'd0);
        send_dates(5'd29, 4'd2, 12'd2000, 5'd1, 4'd3, 12'd2000);
        send_dates(5'd28, 4'd2, 12'd1900, 5'd1, 4'd3, 12'd1900);
        send_dates(5'd28, 4'd2, 12'd2004, 5'd1, 4'd3, 12'd2004);
        send_dates(5'd1, 4'd3, 12'd0, 5'd28, 4'd2, 12'd0);
        send_dates(5'd31, 4'd12, 12'd399, 5'd1, 4'd1, 12'd400);
        // Days past the end of the month are added as given.
        send_dates(5'd31, 4'd2, 12'd2023, 5'd1, 4'd3, 12'd2023);
        send_dates(5'd31, 4'd4, 12'd2021, 5'd1, 4'd5, 12'd2021);
        // Ordering by fields disagrees with the day numbers here.
        send_dates(5'd31, 4'd2, 12'd2001, 5'd2, 4'd3, 12'd2001);
        // Day zero counts as nothing.
        send_dates(5'd0, 4'd1, 12'd100, 5'd1, 4'd1, 12'd100);
        // Month zero adds no months; months past twelve add a full year.
        send_dates(5'd15, 4'd0, 12'd2020, 5'd15, 4'd1, 12'd2020);
        send_dates(5'd1, 4'd13, 12'd1999, 5'd1, 4'd1, 12'd2000);
        send_dates(5'd31, 4'd14, 12'd400, 5'd1, 4'd13, 12'd400);
        send_dates(5'd31, 4'd15, 12'd4095, 5'd0, 4'd0, 12'd0);
        send_dates(5'd0, 4'd0, 12'd0, 5'd31, 4'd15, 12'd4095);
        send_dates(5'd5, 4'd6, 12'd2024, 5'd5, 4'd6, 12'd1024);
        send_dates(5'd10, 4'd10, 12'd2730, 5'd21, 4'd5, 12'd1365);
        drain();
    endtask

    // Well-formed dates, often in the same year so the month table is exercised.
    task automatic run_valid_random(int count);
        day_t   d1;
        day_t   d2;
        month_t m1;
        month_t m2;
        year_t  y1;
        year_t  y2;
        repeat (count)
        begin
            pick_date(-1, d1, m1, y1);
            pick_date(($urandom_range(0, 2) == 0) ? -1 : int'(y1), d2, m2, y2);
            send_dates(d1, m1, y1, d2, m2, y2);
        end
        drain();
    endtask

    // Any value each field can hold.
    task automatic run_noise_random(int count);
        repeat (count)
            send_dates(day_t'($urandom_range(0, 31)), month_t'($urandom_range(0, 15)),
                       year_t'($urandom_range(0, 4095)), day_t'($urandom_range(0, 31)),
                       month_t'($urandom_range(0, 15)), year_t'($urandom_range(0, 4095)));
        drain();
    endtask

    // Full rate on both sides: no gaps and no stalls.
    task automatic run_back_to_back(int count);
        day_t   d1;
        day_t   d2;
        month_t m1;
        month_t m2;
        year_t  y1;
        year_t  y2;
        idle_on = 1'b0;
        repeat (count)
        begin
            pick_date(-1, d1, m1, y1);
            pick_date(-1, d2, m2, y2);
            if ($urandom_range(0, 3) == 0)
                m2 = month_t'($urandom_range(0, 15));
            send_dates(d1, m1, y1, d2, m2, y2);
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_valid_random(450);
        run_noise_random(180);
        run_back_to_back(100);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/dtiv_pkg.sv
hw/rtl/dtiv_day_number.sv
hw/rtl/date_interval_days.sv
verif/tb_top.sv
